/* hdl/gir_pkg.sv */
// Shared types for the gate implication rule block.
`default_nettype none
package gir_pkg;

    // Gate type codes carried on the command field
    typedef enum logic [2:0] {
        GATE_AND  = 3'd0,
        GATE_OR   = 3'd1,
        GATE_XOR  = 3'd2,
        GATE_XOR3 = 3'd3,
        GATE_MAJ  = 3'd4
    } t_gate;

    // Pin order in the pin vectors below
    localparam int unsigned PIN_A = 0;
    localparam int unsigned PIN_B = 1;
    localparam int unsigned PIN_C = 2;
    localparam int unsigned PIN_Y = 3;
    localparam int unsigned NPINS = 4;

    // One registered request
    typedef struct packed {
        logic [2:0]       cmd;
        logic [NPINS-1:0] known;
        logic [NPINS-1:0] value;
        logic [NPINS-1:0] negated;   // output pin entry is always 0
    } t_gate_in;

    // One evaluated result
    typedef struct packed {
        logic             conflict;
        logic [NPINS-1:0] imply;
        logic [NPINS-1:0] implied;
    } t_gate_res;

endpackage : gir_pkg
`default_nettype wire

/* hdl/gir_eval.sv */
// Combinational implication rule for one gate: conflict check and implied pins.
`default_nettype none
module gir_eval (
    input  wire gir_pkg::t_gate_in  i_req,
    output gir_pkg::t_gate_res o_res
);
    import gir_pkg::*;

    logic [NPINS-1:0] lit;       // literal value seen at each pin
    logic [NPINS-1:0] kn;
    logic [NPINS-1:0] imp;
    logic [NPINS-1:0] ilit;      // implied literal value
    logic             cf;
    logic             cv;
    logic             nc;
    logic             ctrl;
    logic [NPINS-1:0] pmask;     // pins that take part in the parity
    logic [NPINS-1:0] punk;
    logic             par;
    logic [1:0]       nk_maj;
    logic [1:0]       sum_maj;
    logic [2:0]       unk_in;

    assign lit = i_req.value ^ i_req.negated;
    assign kn  = i_req.known;

    // Parity and majority helpers
    always_comb begin
        pmask = (i_req.cmd == GATE_XOR3) ? 4'b1111 : 4'b1011;
        punk  = pmask & ~kn;
        par   = ^(lit & kn & pmask);
        unk_in  = ~kn[2:0];
        nk_maj  = 2'(kn[PIN_A]) + 2'(kn[PIN_B]) + 2'(kn[PIN_C]);
        sum_maj = 2'(kn[PIN_A] & lit[PIN_A]) + 2'(kn[PIN_B] & lit[PIN_B])
                + 2'(kn[PIN_C] & lit[PIN_C]);
    end

    // Rule per gate type
    always_comb begin
        cf   = 1'b0;
        imp  = '0;
        ilit = '0;
        cv   = (i_req.cmd == GATE_OR);
        nc   = ~cv;
        ctrl = (kn[PIN_A] && lit[PIN_A] == cv) || (kn[PIN_B] && lit[PIN_B] == cv);
        case (t_gate'(i_req.cmd))
            GATE_AND, GATE_OR: begin
                if (kn[PIN_A] && kn[PIN_B]) begin
                    if (kn[PIN_Y]) begin
                        cf = lit[PIN_Y] != (ctrl ? cv : nc);
                    end else begin
                        imp[PIN_Y]  = 1'b1;
                        ilit[PIN_Y] = ctrl ? cv : nc;
                    end
                end else if (ctrl) begin
                    if (kn[PIN_Y]) begin
                        cf = lit[PIN_Y] != cv;
                    end else begin
                        imp[PIN_Y]  = 1'b1;
                        ilit[PIN_Y] = cv;
                    end
                end else if (kn[PIN_Y]) begin
                    if (lit[PIN_Y] == nc) begin
                        // output at non-controlled value forces every input
                        imp[PIN_A]  = ~kn[PIN_A];
                        imp[PIN_B]  = ~kn[PIN_B];
                        ilit[PIN_A] = nc;
                        ilit[PIN_B] = nc;
                    end else if (kn[PIN_A]) begin
                        imp[PIN_B]  = 1'b1;
                        ilit[PIN_B] = cv;
                    end else if (kn[PIN_B]) begin
                        imp[PIN_A]  = 1'b1;
                        ilit[PIN_A] = cv;
                    end
                end
            end
            GATE_XOR, GATE_XOR3: begin
                if (punk == '0) begin
                    cf = par;
                end else if ($countones(punk) == 1) begin
                    imp  = punk;
                    ilit = {NPINS{par}};
                end
            end
            GATE_MAJ: begin
                if (nk_maj == 2'd3) begin
                    if (kn[PIN_Y]) begin
                        cf = lit[PIN_Y] != sum_maj[1];
                    end else begin
                        imp[PIN_Y]  = 1'b1;
                        ilit[PIN_Y] = sum_maj[1];
                    end
                end else if (nk_maj == 2'd2) begin
                    if (sum_maj != 2'd1) begin
                        // two known inputs agree: they decide the output
                        if (kn[PIN_Y]) begin
                            cf = lit[PIN_Y] != sum_maj[1];
                        end else begin
                            imp[PIN_Y]  = 1'b1;
                            ilit[PIN_Y] = sum_maj[1];
                        end
                    end else if (kn[PIN_Y]) begin
                        imp[2:0]  = unk_in;
                        ilit[2:0] = {3{lit[PIN_Y]}};
                    end
                end else if (nk_maj == 2'd1 && kn[PIN_Y] && sum_maj[0] != lit[PIN_Y]) begin
                    imp[2:0]  = unk_in;
                    ilit[2:0] = {3{lit[PIN_Y]}};
                end
            end
            default: begin
            end
        endcase
    end

    // Conflict clears all implications; write back through the pin negation
    always_comb begin
        o_res.conflict = cf;
        o_res.imply    = cf ? '0 : imp;
        o_res.implied  = cf ? '0 : (imp & (ilit ^ i_req.negated));
    end

endmodule : gir_eval
`default_nettype wire

/* hdl/gate_implication_rule.sv */
// Top level: request register, implication rule and result register.
//
// Usage: drive the gate type and the pin state on the i_ ports and pulse
// start. A request is taken at every rising edge where start is high and
// busy is low; busy never rises, so one request can be issued every cycle.
// The request is registered, evaluated by the rule logic, and the result
// is registered: o_done is high for exactly one cycle once the request has
// passed both registers, with o_conflict and the imply / implied pairs valid
// in that cycle only. Results come out in request order, one per request.
// Throughput is one gate per cycle; the rule logic between the two
// registers sets the cycle time.
// The receiver cannot hold results off and the block never waits on it.
// Synchronous active-low reset clears the request and result strobes, so
// no o_done appears for requests in flight at reset.
`default_nettype none
module gate_implication_rule (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  start,
    output logic busy,
    input  wire  [2:0] i_cmd,
    input  wire  i_a_known,
    input  wire  i_a_value,
    input  wire  i_a_negated,
    input  wire  i_b_known,
    input  wire  i_b_value,
    input  wire  i_b_negated,
    input  wire  i_c_known,
    input  wire  i_c_value,
    input  wire  i_c_negated,
    input  wire  i_y_known,
    input  wire  i_y_value,
    output logic o_done,
    output logic o_conflict,
    output logic o_imply_a,
    output logic o_implied_a,
    output logic o_imply_b,
    output logic o_implied_b,
    output logic o_imply_c,
    output logic o_implied_c,
    output logic o_imply_y,
    output logic o_implied_y
);
    import gir_pkg::*;

    logic      r_req_vld;
    t_gate_in  r_req;
    t_gate_in  n_req;
    logic      r_res_vld;
    t_gate_res r_res;
    t_gate_res n_res;
    logic      accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Pack the request
    always_comb begin
        n_req.cmd     = i_cmd;
        n_req.known   = {i_y_known, i_c_known, i_b_known, i_a_known};
        n_req.value   = {i_y_value, i_c_value, i_b_value, i_a_value};
        n_req.negated = {1'b0, i_c_negated, i_b_negated, i_a_negated};
    end

    // Request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
        end else begin
            r_req_vld <= accept;
        end
        if (accept) begin
            r_req <= n_req;
        end
    end

    gir_eval u_eval (
        .i_req (r_req),
        .o_res (n_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= r_req_vld;
        end
        if (r_req_vld) begin
            r_res <= n_res;
        end
    end

    assign o_done      = r_res_vld;
    assign o_conflict  = r_res.conflict;
    assign o_imply_a   = r_res.imply[PIN_A];
    assign o_implied_a = r_res.implied[PIN_A];
    assign o_imply_b   = r_res.imply[PIN_B];
    assign o_implied_b = r_res.implied[PIN_B];
    assign o_imply_c   = r_res.imply[PIN_C];
    assign o_implied_c = r_res.implied[PIN_C];
    assign o_imply_y   = r_res.imply[PIN_Y];
    assign o_implied_y = r_res.implied[PIN_Y];

    // Each accepted request yields exactly one strobe, through the request and result registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##2 o_done) else $error("missing result strobe");
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |-> ##2 !o_done) else $error("result without request");
    // A conflict never comes with an implication
    a_conflict_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_conflict) |->
            !(o_imply_a || o_imply_b || o_imply_c || o_imply_y))
        else $error("implication reported with conflict");
    // Only unknown variables get implied (checked here on pins A and Y)
    a_imply_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_imply_a && $past(i_a_known, 2))
                && !(o_imply_y && $past(i_y_known, 2)))
        else $error("known variable implied");

endmodule : gate_implication_rule
`default_nettype wire
